[src/kpd_pkg.sv]
// Shared types and constants for the keypad scanner with debounce.
`default_nettype none

package kpd_pkg;

    // Width of a snapshot and of a key index.
    localparam int KEY_BITS = 16;
    localparam int IDX_BITS = 4;
    localparam int CHAR_BITS = 7;
    localparam int CNT_BITS = 8;
    localparam int OUT_DATA_BITS = 16;

    // Character layout of the 4x4 keypad, row by row.
    localparam int LAYOUT_ROWS = 4;
    localparam int LAYOUT_COLS = 4;
    localparam logic [CHAR_BITS-1:0] LAYOUT_CHARS [LAYOUT_ROWS*LAYOUT_COLS] = '{
        7'h31, 7'h32, 7'h33, 7'h41,
        7'h34, 7'h35, 7'h36, 7'h42,
        7'h37, 7'h38, 7'h39, 7'h43,
        7'h2A, 7'h30, 7'h23, 7'h44
    };

    // Reset value of the debounce tick count.
    localparam logic [CNT_BITS-1:0] DEBOUNCE_RESET = 8'd4;

    // Result of the priority encoder.
    typedef struct packed {
        logic                found;
        logic [IDX_BITS-1:0] idx;
    } kpd_enc_t;

endpackage

`default_nettype wire

[src/kpd_encoder.sv]
// Priority encoder that picks the first pressed key of a snapshot.
`default_nettype none

module kpd_encoder #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  wire logic [kpd_pkg::KEY_BITS-1:0] key_matrix,
    output kpd_pkg::kpd_enc_t                 enc
);
    import kpd_pkg::*;

    // Only keys that exist in the matrix and fit the snapshot are visible.
    localparam int VIS_KEYS = (ROWS * COLS < KEY_BITS) ? ROWS * COLS : KEY_BITS;

    logic [KEY_BITS-1:0] visible;

    always_comb
    begin
        for (int i = 0; i < KEY_BITS; i++)
        begin
            visible[i] = (i < VIS_KEYS) ? key_matrix[i] : 1'b0;
        end
    end

    // Rows in order, then columns in order, is simply the lowest set bit.
    always_comb
    begin
        enc.found = |visible;
        enc.idx   = '0;
        for (int i = KEY_BITS - 1; i >= 0; i--)
        begin
            if (visible[i])
            begin
                enc.idx = IDX_BITS'(i);
            end
        end
    end

endmodule

`default_nettype wire

[src/kpd_ctrl.sv]
// Scan, debounce and hold phase machine with the registered release result.
`default_nettype none

module kpd_ctrl #(
    parameter int COLS = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire kpd_pkg::kpd_enc_t             enc,
    input  wire logic [kpd_pkg::CNT_BITS-1:0]  debounce_ticks,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic                               release_valid,
    output logic [kpd_pkg::IDX_BITS-1:0]       release_index,
    output logic [kpd_pkg::CHAR_BITS-1:0]      release_char
);
    import kpd_pkg::*;

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HOLD     = 2'd2
    } phase_t;

    typedef logic [KEY_BITS-1:0][CHAR_BITS-1:0] char_tab_t;

    // Character of every key index, worked out at elaboration.
    function automatic char_tab_t build_char_tab();
        char_tab_t tab;
        int        r;
        int        c;
        for (int i = 0; i < KEY_BITS; i++)
        begin
            r = i / COLS;
            c = i % COLS;
            if (r < LAYOUT_ROWS && c < LAYOUT_COLS)
            begin
                tab[i] = LAYOUT_CHARS[r * LAYOUT_COLS + c];
            end
            else
            begin
                tab[i] = '0;
            end
        end
        return tab;
    endfunction

    localparam char_tab_t CHAR_TAB = build_char_tab();

    phase_t                 phase_reg;
    logic [IDX_BITS-1:0]    held_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic                   out_valid_reg;
    logic                   rel_valid_reg;
    logic [IDX_BITS-1:0]    rel_index_reg;
    logic [CHAR_BITS-1:0]   rel_char_reg;

    logic                   same_key;

    assign same_key = enc.found && (enc.idx == held_reg);

    // Phase state and the result register, advanced once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SCAN;
            held_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            rel_valid_reg <= 1'b0;
            rel_index_reg <= '0;
            rel_char_reg  <= '0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
            rel_valid_reg <= 1'b0;
            rel_index_reg <= '0;
            rel_char_reg  <= '0;
            unique case (phase_reg)
                PH_SCAN:
                begin
                    if (enc.found)
                    begin
                        held_reg  <= enc.idx;
                        count_reg <= '0;
                        phase_reg <= PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (count_reg >= debounce_ticks)
                    begin
                        phase_reg <= same_key ? PH_HOLD : PH_SCAN;
                    end
                    if (count_reg != '1)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                PH_HOLD:
                begin
                    if (!same_key)
                    begin
                        // A release reports the key; another key just rescans.
                        if (!enc.found)
                        begin
                            rel_valid_reg <= 1'b1;
                            rel_index_reg <= held_reg;
                            rel_char_reg  <= CHAR_TAB[held_reg];
                        end
                        phase_reg <= PH_SCAN;
                    end
                end
                default:
                begin
                    phase_reg <= PH_SCAN;
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign release_valid = rel_valid_reg;
    assign release_index = rel_index_reg;
    assign release_char  = rel_char_reg;

endmodule

`default_nettype wire

[src/keypad_scan_debounce.sv]
// Top level of the debounced 4x4 keypad scanner.
//
// Each request on the slave stream is one tick: s_axis_tdata carries a
// snapshot of the keys that read pressed, bit row*COLS+col per key.
// Every request yields exactly one result on the master stream, which
// says whether a held key was released on that tick, and if so which key
// and its ASCII character.
// The debounce tick count resets to 4. The user must write it through
// cfg_wr_en/cfg_wr_data only while the block is idle; the block does not check.
// A request is held in an input register, and its result is then loaded into
// the output register once that register is free. One request per cycle is
// sustained while the receiver does not stall; the cycle is set by the
// priority encoder and the phase update between the two registers.
// When the receiver stalls, the result waits in the output register, the
// input register still takes one more request, and s_axis_tready then
// drops until the result is taken.
// Reset empties both registers, returns the machine to the scan phase and
// clears the held key and the debounce count.
`default_nettype none

module keypad_scan_debounce #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [kpd_pkg::CNT_BITS-1:0]      cfg_wr_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [15:0] key_matrix
    input  wire logic [kpd_pkg::KEY_BITS-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] release_valid, [4:1] release_index, [11:5] release_char, [15:12] zero
    output logic [kpd_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata
);
    import kpd_pkg::*;

    logic [CNT_BITS-1:0]  ticks_reg;
    logic                 in_valid_reg;
    logic [KEY_BITS-1:0]  in_data_reg;
    logic                 step;
    logic                 in_take;
    kpd_enc_t             enc;
    logic                 rel_valid;
    logic [IDX_BITS-1:0]  rel_index;
    logic [CHAR_BITS-1:0] rel_char;

    // The held request moves on whenever the output register is free.
    assign step          = in_valid_reg && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Debounce tick count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= DEBOUNCE_RESET;
        end
        else if (cfg_wr_en)
        begin
            ticks_reg <= cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    kpd_encoder #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_encoder (
        .key_matrix (in_data_reg),
        .enc        (enc)
    );

    kpd_ctrl #(
        .COLS (COLS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .enc            (enc),
        .debounce_ticks (ticks_reg),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .release_valid  (rel_valid),
        .release_index  (rel_index),
        .release_char   (rel_char)
    );

    // Pack the result fields, lowest field first.
    assign m_axis_tdata = {
        {(OUT_DATA_BITS - 1 - IDX_BITS - CHAR_BITS){1'b0}},
        rel_char,
        rel_index,
        rel_valid
    };

endmodule

`default_nettype wire
